### rtl/tts_pkg.sv
// Shared types and constants for the tick task scheduler.
package tts_pkg;

    // Request codes
    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_CREATE = 2'd1,
        MODE_SET    = 2'd2,
        MODE_WAIT   = 2'd3
    } mode_t;

    // Most run results reported for one tick
    localparam int MAX_RUNS = 8;
    localparam int RUN_CNT_W = 4;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  task_id;
        logic [2:0]  slot;
        logic [15:0] value;
    } req_t;

    typedef struct packed {
        logic       run_valid;
        logic [2:0] run_slot;
        logic [2:0] run_id;
        logic [7:0] run_state;
        logic       accepted;
        logic       last;
    } rsp_t;

    // Contents of one table slot
    typedef struct packed {
        logic        waiting;
        logic [15:0] delay;
        logic [2:0]  ident;
        logic [7:0]  ustate;
    } entry_t;

endpackage

### rtl/tts_cell.sv
// One table slot: holds its entry, shifts along the chain or takes a write.
module tts_cell (
    input  logic            clk,
    input  logic            shift_en,
    input  tts_pkg::entry_t shift_in,
    input  logic            wr_en,
    input  tts_pkg::req_t   cmd,
    output tts_pkg::entry_t entry
);
    import tts_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (shift_en)
        begin
            entry_next = shift_in;
        end
        else if (wr_en)
        begin
            unique case (cmd.mode)
                MODE_CREATE:
                begin
                    entry_next.waiting = 1'b0;
                    entry_next.delay   = 16'd1;
                    entry_next.ident   = cmd.task_id[2:0];
                    entry_next.ustate  = 8'd0;
                end
                MODE_SET:
                begin
                    entry_next.ustate = cmd.value[7:0];
                end
                MODE_WAIT:
                begin
                    entry_next.delay   = cmd.value;
                    entry_next.waiting = 1'b1;
                end
                default:
                begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### rtl/tick_task_delay_scheduler_unit.sv
// Top level of the tick task scheduler: cell chain plus sweep control.
//
//  channel  | ports                 | handshake
//  ---------+-----------------------+---------------------------------------
//  request  | req (req_t)           | taken at clk edge with start & !busy
//  result   | rsp (rsp_t)           | valid one cycle while done is high
//
//  Create, set and wait requests answer without a sweep: the result shows on the
//  cycle after the request and busy stays low, so requests can come back to
//  back. A tick sweeps the table: the slot chain rotates one place per
//  cycle past the head evaluator, then a closing state flushes the last
//  run result. busy is high for the sweep and the closing state.
//  Reset clears the task count and control; slot contents are undefined
//  until a create writes them. Results cannot be stalled by the receiver.
module tick_task_delay_scheduler_unit #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  tts_pkg::req_t req,
    output logic          done,
    output tts_pkg::rsp_t rsp
);
    import tts_pkg::*;

    // Count holds 0..TABLE_DEPTH, step indexes 0..TABLE_DEPTH-1
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int STEP_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMP_W  = CNT_W + STEP_W + 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [RUN_CNT_W-1:0]   nrun_reg, nrun_next;
    logic                   pend_valid_reg, pend_valid_next;
    rsp_t                   pend_reg, pend_next;
    logic                   done_reg, done_next;
    rsp_t                   rsp_reg, rsp_next;

    entry_t                 entries [TABLE_DEPTH];
    entry_t                 head_out;
    logic [TABLE_DEPTH-1:0] wr_en;

    logic accept;
    logic create_ok;
    logic slot_ok;
    logic head_occ;
    logic head_run;
    logic shift_en;

    assign accept   = start && (state_reg == ST_IDLE);
    assign shift_en = (state_reg == ST_SWEEP);

    // A create needs a legal id and a free slot; set and wait need an
    // occupied slot.
    assign create_ok = ({1'b0, req.task_id} < 9'(TABLE_DEPTH))
                    && (count_reg < CNT_W'(TABLE_DEPTH));
    assign slot_ok   = (CMP_W'(req.slot) < CMP_W'(count_reg));

    // Head evaluator: slot under the head is the one numbered step_reg
    assign head_occ = (CMP_W'(step_reg) < CMP_W'(count_reg));
    assign head_run = head_occ && (!entries[0].waiting || (entries[0].delay == 16'd0));

    always_comb
    begin
        head_out = entries[0];
        if (head_occ)
        begin
            if (head_run)
            begin
                head_out.waiting = 1'b0;
            end
            else
            begin
                head_out.delay = entries[0].delay - 16'd1;
            end
        end
    end

    // Slot chain; slot i sits in cell i while idle
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        entry_t sin;
        logic   sel;

        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign sin = head_out;
        end
        else
        begin : g_mid
            assign sin = entries[i+1];
        end

        if (i < 8)
        begin : g_addr
            assign sel = (req.mode == MODE_CREATE)
                       ? (create_ok && (count_reg == CNT_W'(i)))
                       : (slot_ok && (req.slot == 3'(i)));
        end
        else
        begin : g_noaddr
            assign sel = (req.mode == MODE_CREATE)
                       && create_ok && (count_reg == CNT_W'(i));
        end

        assign wr_en[i] = accept && (req.mode != MODE_TICK) && sel;

        tts_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .shift_in (sin),
            .wr_en    (wr_en[i]),
            .cmd      (req),
            .entry    (entries[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        nrun_next       = nrun_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.mode == MODE_TICK)
                    begin
                        state_next      = ST_SWEEP;
                        step_next       = '0;
                        nrun_next       = '0;
                        pend_valid_next = 1'b0;
                    end
                    else
                    begin
                        done_next     = 1'b1;
                        rsp_next      = '0;
                        rsp_next.last = 1'b1;
                        if (req.mode == MODE_CREATE)
                        begin
                            rsp_next.accepted = create_ok;
                            if (create_ok)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            rsp_next.accepted = slot_ok;
                        end
                    end
                end
            end
            ST_SWEEP:
            begin
                // Hold one run back so the final one can carry last
                if (head_run && (nrun_reg < RUN_CNT_W'(MAX_RUNS)))
                begin
                    if (pend_valid_reg)
                    begin
                        done_next = 1'b1;
                        rsp_next  = pend_reg;
                    end
                    pend_next           = '0;
                    pend_next.run_valid = 1'b1;
                    pend_next.run_slot  = 3'(step_reg);
                    pend_next.run_id    = entries[0].ident;
                    pend_next.run_state = entries[0].ustate;
                    pend_valid_next     = 1'b1;
                    nrun_next           = nrun_reg + RUN_CNT_W'(1);
                end
                if (step_reg == STEP_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_FINISH:
            begin
                done_next = 1'b1;
                rsp_next  = pend_valid_reg ? pend_reg : '0;
                rsp_next.last = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            step_reg       <= '0;
            nrun_reg       <= '0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            nrun_reg       <= nrun_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // A result never both runs a task and acknowledges a request
    a_run_xor_acc: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.run_valid && rsp.accepted))
        else $error("run result flagged as accepted");

    // Dropping busy coincides with the closing result of a tick
    a_tick_close: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (done && rsp.last))
        else $error("tick ended without a last result");

    // Intermediate results only come out during a sweep
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.last) |-> busy)
        else $error("non-final result while idle");

    // Non-tick requests answer on the next cycle with a single last result
    a_cmd_one: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.mode != MODE_TICK)) |=> (done && rsp.last && !busy))
        else $error("request did not complete in one cycle");

endmodule

### bench/testbench.sv
// Self-checking bench for the tick task scheduler: directed and random requests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    // Table depth of the scheduler under test. A slot index is 3 bits wide,
    // so every slot a request can address is inside the table.
    localparam int DEPTH       = 8;
    // Bound for the watchdog; 104 requests with their gaps stay far below this.
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    tick_task_delay_scheduler_unit #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Requests waiting to be driven, and results the scheduler still owes us.
    req_t req_backlog[$];
    rsp_t results_due[$];

    // Our own copy of the task table.
    int unsigned tasks_live;
    entry_t      task_table[DEPTH];

    int   error_count = 0;
    int   cycle_count = 0;
    int   gap_left    = 0;
    logic req_taken   = 1'b0;

    // Apply one accepted request to the table copy and queue the results it
    // must produce, in order, with last set on the final one.
    function automatic void schedule_request(req_t r);
        rsp_t held;
        rsp_t reply;
        bit   have_held;
        bit   took_effect;

        held        = '0;
        reply       = '0;
        have_held   = 1'b0;
        took_effect = 1'b0;
        if (r.mode == MODE_TICK)
        begin
            // Walk occupied slots in order: running tasks and expired waits
            // run, everything else counts down by one.
            for (int i = 0; i < tasks_live; i++)
            begin
                if (!task_table[i].waiting || task_table[i].delay == 16'd0)
                begin
                    task_table[i].waiting = 1'b0;
                    if (have_held)
                        results_due.push_back(held);
                    held           = '0;
                    held.run_valid = 1'b1;
                    held.run_slot  = 3'(i);
                    held.run_id    = task_table[i].ident;
                    held.run_state = task_table[i].ustate;
                    have_held      = 1'b1;
                end
                else
                begin
                    task_table[i].delay = task_table[i].delay - 16'd1;
                end
            end
            if (have_held)
            begin
                held.last = 1'b1;
                results_due.push_back(held);
            end
            else
            begin
                // idle tick: one empty result
                reply.last = 1'b1;
                results_due.push_back(reply);
            end
        end
        else
        begin
            if (r.mode == MODE_CREATE)
            begin
                // refused when the id is out of range or the table is full
                if (r.task_id < DEPTH && tasks_live < DEPTH)
                begin
                    task_table[tasks_live].waiting = 1'b0;
                    task_table[tasks_live].delay   = 16'd1;
                    task_table[tasks_live].ident   = r.task_id[2:0];
                    task_table[tasks_live].ustate  = 8'd0;
                    tasks_live++;
                    took_effect = 1'b1;
                end
            end
            else if (r.slot < tasks_live)
            begin
                if (r.mode == MODE_SET)
                    task_table[r.slot].ustate = r.value[7:0];
                else
                begin
                    task_table[r.slot].delay   = r.value;
                    task_table[r.slot].waiting = 1'b1;
                end
                took_effect = 1'b1;
            end
            // set/wait on an empty slot is ignored and reports accepted 0
            reply.accepted = took_effect;
            reply.last     = 1'b1;
            results_due.push_back(reply);
        end
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    function automatic void add_req(mode_t m, logic [7:0] id, logic [2:0] s,
                                    logic [15:0] v);
        req_t r;

        r.mode    = m;
        r.task_id = id;
        r.slot    = s;
        r.value   = v;
        req_backlog.push_back(r);
    endfunction

    // Driver: changes inputs on the falling edge. A request stays up until
    // the monitor has seen it taken, then an optional gap follows.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !req_taken)
        begin
            // still waiting for the scheduler to take it
        end
        else if (gap_left > 0)
        begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (req_backlog.size() > 0)
        begin
            req   <= req_backlog.pop_front();
            start <= 1'b1;
            // mostly back to back, some short gaps, now and then a long one
            gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                      : ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // Monitor: samples on the rising edge. Results are checked before the
    // request taken at this same edge is predicted; its results come later.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, rsp);
                    error_count++;
                end
                else
                begin
                    rsp_t want;

                    want = results_due.pop_front();
                    check_field("run_valid", want.run_valid, rsp.run_valid);
                    check_field("run_slot", want.run_slot, rsp.run_slot);
                    check_field("run_id", want.run_id, rsp.run_id);
                    check_field("run_state", want.run_state, rsp.run_state);
                    check_field("accepted", want.accepted, rsp.accepted);
                    check_field("last", want.last, rsp.last);
                end
            end
            if (start && !busy)
                schedule_request(req);
            req_taken <= start && !busy;
        end
        else
        begin
            req_taken <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[tick_task_delay_scheduler_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned pick;

        tasks_live = 0;
        foreach (task_table[i])
            task_table[i] = '0;

        // Directed: empty table, refused creates, ignored set/wait.
        add_req(MODE_TICK, 8'd0, 3'd0, 16'd0);
        add_req(MODE_CREATE, 8'd8, 3'd0, 16'd0);
        add_req(MODE_CREATE, 8'd255, 3'd7, 16'hFFFF);
        add_req(MODE_SET, 8'd0, 3'd0, 16'h00FF);
        add_req(MODE_WAIT, 8'd0, 3'd7, 16'd5);
        // Two tasks, run once, then zero and short delays.
        add_req(MODE_CREATE, 8'd0, 3'd0, 16'd0);
        add_req(MODE_CREATE, 8'd7, 3'd0, 16'd0);
        add_req(MODE_TICK, 8'd0, 3'd0, 16'd0);
        add_req(MODE_SET, 8'd0, 3'd1, 16'hFFAB);
        add_req(MODE_WAIT, 8'd0, 3'd0, 16'd0);
        add_req(MODE_WAIT, 8'd0, 3'd1, 16'd2);
        add_req(MODE_TICK, 8'd0, 3'd0, 16'd0);
        add_req(MODE_TICK, 8'd0, 3'd0, 16'd0);
        add_req(MODE_TICK, 8'd0, 3'd0, 16'd0);
        // Fill the table, then one create too many.
        for (int i = 1; i < DEPTH - 1; i++)
            add_req(MODE_CREATE, 8'(i), 3'd0, 16'd0);
        add_req(MODE_CREATE, 8'd3, 3'd0, 16'd0);
        add_req(MODE_SET, 8'd0, 3'd7, 16'h5A00);
        add_req(MODE_WAIT, 8'd0, 3'd3, 16'hFFFF);
        add_req(MODE_TICK, 8'd0, 3'd0, 16'd0);

        // Random part: tick heavy, short delays so waits actually expire.
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                add_req(MODE_TICK, 8'($urandom), 3'($urandom), 16'($urandom));
            else if (pick < 52)
                add_req(MODE_CREATE, 8'($urandom), 3'($urandom), 16'($urandom));
            else if (pick < 72)
                add_req(MODE_SET, 8'($urandom), 3'($urandom), 16'($urandom));
            else if ($urandom_range(0, 4) != 0)
                add_req(MODE_WAIT, 8'($urandom), 3'($urandom), 16'($urandom_range(0, 3)));
            else
                add_req(MODE_WAIT, 8'($urandom), 3'($urandom), 16'($urandom));
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Let every request go out, then drain the owed results.
        while (req_backlog.size() > 0 || start)
            @(negedge clk);
        while (results_due.size() > 0)
            @(negedge clk);
        // wait past the end of any tick to catch a stray trailing result
        repeat (4 * DEPTH) @(negedge clk);

        if (error_count == 0 && results_due.size() == 0)
            $display("[tick_task_delay_scheduler_unit] OK");
        else
            $display("[tick_task_delay_scheduler_unit] ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/tts_pkg.sv
rtl/tts_cell.sv
rtl/tick_task_delay_scheduler_unit.sv
bench/testbench.sv
